### rtl/core/ljpf_pkg.sv
// ----------------------------------------------------------------------------
// ljpf_pkg: shared types for the Lennard-Jones pair force pipeline
// Holds the record that travels beside the arithmetic through every stage.
// ----------------------------------------------------------------------------
package ljpf_pkg;

  localparam int unsigned MAG_W = 31;
  localparam int unsigned R2_W  = 62;
  localparam int unsigned Q_W   = 64;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  far;
    logic                  live;
    logic                  sat;
    logic [31:0]           cut;
    logic [31:0]           c6;
    logic [31:0]           c12;
    logic [31:0]           e6;
    logic [31:0]           e12;
    logic [R2_W-1:0]       r2;
    logic [Q_W-1:0]        r2inv;
    logic [Q_W-1:0]        r6inv;
    logic [Q_W-1:0]        smag;
    logic                  sneg;
    logic                  eneg;
    logic [Q_W-1:0]        emag;
  } pipe_t;

endpackage

### rtl/core/lj_pair_force.sv
// ----------------------------------------------------------------------------
// lj_pair_force: Lennard-Jones 12-6 pair force and energy, fixed point
// Throughput is one pair per cycle; the whole pipeline advances together
// and holds when the output register is full and not taken.
// The reciprocal is a restoring divider with one quotient bit per stage.
// Synchronous reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
module lj_pair_force #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] pos_i_x,
  input  logic signed [COORD_WIDTH-1:0] pos_i_y,
  input  logic signed [COORD_WIDTH-1:0] pos_i_z,
  input  logic signed [COORD_WIDTH-1:0] pos_j_x,
  input  logic signed [COORD_WIDTH-1:0] pos_j_y,
  input  logic signed [COORD_WIDTH-1:0] pos_j_z,
  input  logic        [31:0]            cutoff_sq,
  input  logic        [31:0]            coef_c6,
  input  logic        [31:0]            coef_c12,
  input  logic        [31:0]            coef_e6,
  input  logic        [31:0]            coef_e12,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [63:0]            force_x,
  output logic signed [63:0]            force_y,
  output logic signed [63:0]            force_z,
  output logic signed [63:0]            pair_energy,
  output logic                          in_range,
  output logic                          saturated
);

  localparam int K     = 2 * FRAC_BITS + 32;
  localparam int DEPTH = K + 18;
  localparam int SH    = 32 - FRAC_BITS;
  localparam logic [63:0] TOP = 64'h8000_0000_0000_0000;

  logic en;
  logic [DEPTH-1:0] vsr;

  assign en        = !vsr[DEPTH-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vsr[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vsr <= '0;
    end else if (en) begin
      vsr <= {vsr[DEPTH-2:0], in_valid};
    end
  end

  // Input stage: displacement magnitudes and signs.
  logic signed [COORD_WIDTH:0] d [3];
  logic        [COORD_WIDTH:0] dm [3];
  logic        [63:0]          dm64 [3];
  ljpf_pkg::pipe_t p0_in, p0, p1, p2, p2_next;

  always_comb begin
    d[0] = {pos_j_x[COORD_WIDTH-1], pos_j_x} - {pos_i_x[COORD_WIDTH-1], pos_i_x};
    d[1] = {pos_j_y[COORD_WIDTH-1], pos_j_y} - {pos_i_y[COORD_WIDTH-1], pos_i_y};
    d[2] = {pos_j_z[COORD_WIDTH-1], pos_j_z} - {pos_i_z[COORD_WIDTH-1], pos_i_z};
    p0_in      = '0;
    p0_in.cut  = cutoff_sq;
    p0_in.c6   = coef_c6;
    p0_in.c12  = coef_c12;
    p0_in.e6   = coef_e6;
    p0_in.e12  = coef_e12;
    for (int c = 0; c < 3; c++) begin
      dm[c]           = d[c][COORD_WIDTH] ? -d[c] : d[c];
      dm64[c]         = 64'(dm[c]);
      p0_in.neg[c]    = d[c][COORD_WIDTH];
      p0_in.mag[c]    = dm64[c][30:0];
      if (|dm64[c][63:31]) p0_in.far = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) p0 <= p0_in;
  end

  // Squares, then r squared and the range test.
  logic [61:0] sq [3];
  logic [63:0] r2_sum, thresh;

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= p0;
      for (int c = 0; c < 3; c++) sq[c] <= 62'(p0.mag[c]) * 62'(p0.mag[c]);
    end
  end

  always_comb begin
    r2_sum       = 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
    thresh       = 64'(p1.cut) << FRAC_BITS;
    p2_next      = p1;
    p2_next.r2   = r2_sum[61:0];
    p2_next.live = !p1.far && (r2_sum != 64'd0) && (r2_sum < thresh);
  end

  always_ff @(posedge clk) begin
    if (en) p2 <= p2_next;
  end

  // Restoring divider: floor(2^K / r2), one quotient bit per stage.
  logic [62:0]     drem [0:K];
  logic [63:0]     dq   [0:K];
  logic            dovf [0:K];
  ljpf_pkg::pipe_t dp   [0:K];

  for (genvar i = 0; i <= K; i++) begin : g_div
    logic [62:0]     rem_in, sh, rem_out;
    logic [63:0]     q_in;
    logic            ovf_in, ge;
    ljpf_pkg::pipe_t pin;
    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
      assign ovf_in = 1'b0;
      assign pin    = p2;
    end else begin : g_next
      assign rem_in = drem[i-1];
      assign q_in   = dq[i-1];
      assign ovf_in = dovf[i-1];
      assign pin    = dp[i-1];
    end
    always_comb begin
      sh      = {rem_in[61:0], (i == 0) ? 1'b1 : 1'b0};
      ge      = sh >= {1'b0, pin.r2};
      rem_out = ge ? sh - {1'b0, pin.r2} : sh;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        drem[i] <= rem_out;
        dq[i]   <= {q_in[62:0], ge};
        dovf[i] <= ovf_in | q_in[63];
        dp[i]   <= pin;
      end
    end
  end

  // r6inv = (r2inv * r2inv) * r2inv.
  ljpf_pkg::pipe_t pa_in, pa1, pa2, pb1, pb2, pc1, pc2, pd, pe1, pe2;
  ljpf_pkg::pipe_t pg_in, pg1, pg2, ph1, ph2;
  ljpf_pkg::pipe_t pb1_next, pc1_next, pd_next, ph1_next;
  logic [63:0] ma, mb, mc, md, me, mf, mg;
  logic        sa, sb, sc, sd, se, sf, sg;

  always_comb begin
    pa_in       = dp[K];
    pa_in.r2inv = dovf[K] ? '1 : dq[K];
    pa_in.sat   = dovf[K];
  end

  ljpf_mulq u_mul_a (.clk(clk), .en(en), .a(pa_in.r2inv), .b(pa_in.r2inv), .p(ma), .sat(sa));
  ljpf_mulq u_mul_b (.clk(clk), .en(en), .a(ma), .b(pa2.r2inv), .p(mb), .sat(sb));

  always_comb begin
    pb1_next     = pa2;
    pb1_next.sat = pa2.sat | sa;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa1       <= pa_in;
      pa2       <= pa1;
      pb1       <= pb1_next;
      pb2       <= pb1;
    end
  end

  // Coefficient products against r6inv.
  logic [63:0] r6i;
  assign r6i = mb;

  ljpf_mulq u_mul_c (.clk(clk), .en(en), .a(r6i), .b(64'(pb2.c12) << SH), .p(mc), .sat(sc));
  ljpf_mulq u_mul_d (.clk(clk), .en(en), .a(r6i), .b(64'(pb2.e12) << SH), .p(md), .sat(sd));

  always_comb begin
    pc1_next       = pb2;
    pc1_next.r6inv = r6i;
    pc1_next.sat   = pb2.sat | sb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc1       <= pc1_next;
      pc2       <= pc1;
    end
  end

  // Differences as sign and magnitude.
  logic [63:0] c6q, e6q;
  assign c6q = 64'(pc2.c6) << SH;
  assign e6q = 64'(pc2.e6) << SH;

  always_comb begin
    pd_next      = pc2;
    pd_next.sat  = pc2.sat | sc | sd;
    pd_next.sneg = mc < c6q;
    pd_next.smag = (mc < c6q) ? c6q - mc : mc - c6q;
    pd_next.eneg = md < e6q;
    pd_next.emag = (md < e6q) ? e6q - md : md - e6q;
  end

  always_ff @(posedge clk) begin
    if (en) pd <= pd_next;
  end

  ljpf_mulq u_mul_e (.clk(clk), .en(en), .a(pd.r6inv), .b(pd.smag), .p(me), .sat(se));
  ljpf_mulq u_mul_f (.clk(clk), .en(en), .a(pd.r6inv), .b(pd.emag), .p(mf), .sat(sf));

  always_ff @(posedge clk) begin
    if (en) begin
      pe1 <= pd;
      pe2 <= pe1;
    end
  end

  // Force scalar times r2inv; energy doubled.
  always_comb begin
    pg_in     = pe2;
    pg_in.sat = pe2.sat | se | sf | mf[63];
    pg_in.emag = mf[63] ? '1 : {mf[62:0], 1'b0};
  end

  ljpf_mulq u_mul_g (.clk(clk), .en(en), .a(me), .b(pe2.r2inv), .p(mg), .sat(sg));

  always_comb begin
    ph1_next     = pg2;
    ph1_next.sat = pg2.sat | sg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pg1     <= pg_in;
      pg2     <= pg1;
      ph1     <= ph1_next;
      ph2     <= ph1;
    end
  end

  // Components.
  logic [63:0] mh [3];
  logic        sh3 [3];

  for (genvar c = 0; c < 3; c++) begin : g_comp
    ljpf_mulq u_mul_h (
      .clk(clk), .en(en), .a(64'(pg2.mag[c]) << SH), .b(mg), .p(mh[c]), .sat(sh3[c])
    );
  end

  function automatic logic [64:0] pack_signed(input logic neg, input logic [63:0] mag);
    logic [64:0] r;
    if (neg) begin
      if (mag > TOP) r = {1'b1, TOP};
      else r = {1'b0, 64'd0 - mag};
    end else begin
      if (mag[63]) r = {1'b1, TOP - 64'd1};
      else r = {1'b0, mag};
    end
    return r;
  endfunction

  logic [64:0] pk [4];
  logic        sat_all;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pk[c] = pack_signed((mh[c] != 64'd0) && (ph2.neg[c] != ph2.sneg), mh[c]);
    end
    pk[3]   = pack_signed((ph2.emag != 64'd0) && ph2.eneg, ph2.emag);
    sat_all = ph2.sat | sh3[0] | sh3[1] | sh3[2] |
              pk[0][64] | pk[1][64] | pk[2][64] | pk[3][64];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ph2.live) begin
        force_x     <= pk[0][63:0];
        force_y     <= pk[1][63:0];
        force_z     <= pk[2][63:0];
        pair_energy <= pk[3][63:0];
        in_range    <= 1'b1;
        saturated   <= sat_all;
      end else begin
        force_x     <= '0;
        force_y     <= '0;
        force_z     <= '0;
        pair_energy <= '0;
        in_range    <= 1'b0;
        saturated   <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/ljpf_mulq.sv
// ----------------------------------------------------------------------------
// ljpf_mulq: unsigned Q32.32 multiplier, two stages
// Four 32x32 partial products are registered, then summed and truncated,
// holding the result at all ones on overflow.
// ----------------------------------------------------------------------------
module ljpf_mulq (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p,
  output logic        sat
);

  logic [63:0] p0, p1, p2, p3;
  logic [33:0] mid;
  logic [65:0] hi;

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= 64'(a[31:0])  * 64'(b[31:0]);
      p1 <= 64'(a[31:0])  * 64'(b[63:32]);
      p2 <= 64'(a[63:32]) * 64'(b[31:0]);
      p3 <= 64'(a[63:32]) * 64'(b[63:32]);
    end
  end

  always_comb begin
    mid = 34'(p0[63:32]) + 34'(p1[31:0]) + 34'(p2[31:0]);
    hi  = 66'(p3) + 66'(p1[63:32]) + 66'(p2[63:32]) + 66'(mid[33:32]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if ((|p3[63:32]) || (|hi[65:32])) begin
        p   <= '1;
        sat <= 1'b1;
      end else begin
        p   <= {hi[31:0], mid[31:0]};
        sat <= 1'b0;
      end
    end
  end

endmodule
